// File: rtl/core/tlr_pkg.sv
// types, constants and helpers shared by the thick line rasterizer
// no dependencies; compile first
package tlr_pkg;

    localparam int CoordBits  = 12;
    localparam int PixBits    = CoordBits + 1;
    localparam int DecBits    = CoordBits + 5;
    localparam int PixPerStep = 5;
    localparam int IdxBits    = $clog2(PixPerStep);

    typedef logic signed [CoordBits-1:0] t_coord;
    typedef logic signed [PixBits-1:0]   t_pix;
    typedef logic signed [PixBits-1:0]   t_diff;
    typedef logic signed [DecBits-1:0]   t_dec;
    typedef logic [IdxBits-1:0]          t_idx;

    localparam t_idx LastIdx = t_idx'(PixPerStep - 1);

    localparam logic OpStart = 1'b0;
    localparam logic OpStep  = 1'b1;

    typedef enum logic [1:0] {
        ClsShallowPos = 2'd0,
        ClsSteepPos   = 2'd1,
        ClsShallowNeg = 2'd2,
        ClsSteepNeg   = 2'd3
    } t_class;

    typedef struct packed {
        t_class cls;
        t_coord major_pos;
        t_coord minor_pos;
        t_coord major_end;
        t_diff  delta_y;
        t_diff  neg_delta_x;
        t_dec   decision;
    } t_line;

    // one step's worth of pixel positions, handed to the emitter
    typedef struct packed {
        t_coord major;
        t_coord minor;
        logic   steep;
        logic   done;
    } t_snap;

    // offset across the minor axis for each pixel of a step
    function automatic t_pix pix_offset(t_idx idx);
        t_pix off;
        unique case (idx)
            t_idx'(0): off = t_pix'(0);
            t_idx'(1): off = t_pix'(1);
            t_idx'(2): off = -t_pix'(1);
            t_idx'(3): off = t_pix'(2);
            t_idx'(4): off = -t_pix'(2);
            default:   off = t_pix'(0);
        endcase
        return off;
    endfunction

endpackage

// File: rtl/core/tlr_if.sv
// valid/ready channel interfaces for the line rasterizer
// depends on tlr_pkg
interface tlr_in_if import tlr_pkg::*; ();
    logic   valid;
    logic   ready;
    logic   operation;
    t_coord start_x;
    t_coord start_y;
    t_coord end_x;
    t_coord end_y;

    modport source (output valid, operation, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, operation, start_x, start_y, end_x, end_y, output ready);
endinterface

interface tlr_out_if import tlr_pkg::*; ();
    logic valid;
    logic ready;
    t_pix pixel_x;
    t_pix pixel_y;
    logic last_of_step;
    logic line_done;

    modport source (output valid, pixel_x, pixel_y, last_of_step, line_done, input ready);
    modport sink   (input valid, pixel_x, pixel_y, last_of_step, line_done, output ready);
endinterface

// File: rtl/core/tlr_setup.sv
// line setup: slope class, endpoint ordering and start decision value
// depends on tlr_pkg
module tlr_setup import tlr_pkg::*; (
    input  t_coord i_x0,
    input  t_coord i_y0,
    input  t_coord i_x1,
    input  t_coord i_y1,
    output t_line  o_line,
    output logic   o_point
);

    t_diff  dx, dy, adx, ady, a, b;
    t_class cls;
    logic   swap;
    t_coord sx0, sy0, sx1, sy1;
    t_dec   ea, eb;

    always_comb begin
        dx  = t_diff'(i_x1) - t_diff'(i_x0);
        dy  = t_diff'(i_y1) - t_diff'(i_y0);
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        o_point = (dx == '0) && (dy == '0);

        priority if (dx == '0) begin
            cls = (dy > 0) ? ClsSteepPos : ClsSteepNeg;
        end else if ((dy == '0) || ((dx > 0) == (dy > 0))) begin
            cls = (ady <= adx) ? ClsShallowPos : ClsSteepPos;
        end else begin
            cls = (ady <= adx) ? ClsShallowNeg : ClsSteepNeg;
        end

        swap = (cls == ClsSteepPos) ? (i_y0 > i_y1) : (i_x0 > i_x1);
        sx0  = swap ? i_x1 : i_x0;
        sy0  = swap ? i_y1 : i_y0;
        sx1  = swap ? i_x0 : i_x1;
        sy1  = swap ? i_y0 : i_y1;

        a  = t_diff'(sy1) - t_diff'(sy0);
        b  = t_diff'(sx0) - t_diff'(sx1);
        ea = t_dec'(a);
        eb = t_dec'(b);

        o_line.cls         = cls;
        o_line.delta_y     = a;
        o_line.neg_delta_x = b;
        if ((cls == ClsShallowPos) || (cls == ClsShallowNeg)) begin
            o_line.major_pos = sx0;
            o_line.minor_pos = sy0;
            o_line.major_end = sx1;
        end else begin
            o_line.major_pos = sy0;
            o_line.minor_pos = sx0;
            o_line.major_end = sy1;
        end

        unique case (cls)
            ClsShallowPos: o_line.decision = (ea <<< 1) + eb;
            ClsSteepPos:   o_line.decision = ea + (eb <<< 1);
            ClsShallowNeg: o_line.decision = (ea <<< 1) - eb;
            ClsSteepNeg:   o_line.decision = ea - (eb <<< 1);
            default:       o_line.decision = '0;
        endcase
    end

endmodule

// File: rtl/core/tlr_emit.sv
// pixel emitter: expands one step into five pixel beats through an output register
// depends on tlr_pkg and tlr_if
module tlr_emit import tlr_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  t_snap           i_snap,
    output logic            o_take,
    tlr_out_if.source       o_pix
);

    logic  r_active;
    t_idx  r_idx;
    t_snap r_snap;
    logic  r_out_valid;
    t_pix  r_px, r_py;
    logic  r_last, r_done;

    logic  out_load;
    t_pix  major_ext, minor_ext;

    assign out_load = !r_out_valid || o_pix.ready;
    assign o_take   = !r_active || ((r_idx == LastIdx) && out_load);

    always_comb begin
        major_ext = t_pix'(r_snap.major);
        minor_ext = t_pix'(r_snap.minor) + pix_offset(r_idx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= r_active;
            end
            // a new step takes over as the last pixel of the previous one leaves
            if (i_load) begin
                r_active <= 1'b1;
                r_idx    <= '0;
            end else if (out_load && r_active) begin
                r_idx <= r_idx + t_idx'(1);
                if (r_idx == LastIdx) begin
                    r_active <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_snap <= i_snap;
        end
        if (out_load && r_active) begin
            r_px   <= r_snap.steep ? minor_ext : major_ext;
            r_py   <= r_snap.steep ? major_ext : minor_ext;
            r_last <= (r_idx == LastIdx);
            r_done <= r_snap.done;
        end
    end

    assign o_pix.valid        = r_out_valid;
    assign o_pix.pixel_x      = r_px;
    assign o_pix.pixel_y      = r_py;
    assign o_pix.last_of_step = r_last;
    assign o_pix.line_done    = r_done;

endmodule

// File: rtl/core/thick_line_rasterizer.sv
// thick line rasterizer top level: input register, line state, step update
// depends on tlr_pkg, tlr_if, tlr_setup and tlr_emit
// a step beat passes the input, emitter step and output registers to reach the output
// throughput: a step yields five pixel beats, one per cycle while the output is not
//   stalled, through the single output register; start beats are taken one per cycle
// reset: synchronous, active low; clears the line busy flag and line state, the input
//   register valid and the emitter and output valids
module thick_line_rasterizer import tlr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tlr_in_if.sink     i_line,
    tlr_out_if.source  o_pix
);

    logic   r_in_valid;
    logic   r_op;
    t_coord r_x0, r_y0, r_x1, r_y1;

    logic   r_busy, n_busy;
    t_line  r_line, n_line;

    t_line  setup_line;
    logic   setup_point;
    t_snap  snap;
    logic   em_take, em_load;
    logic   consume, start_go, step_go;
    t_dec   ea, eb;

    tlr_setup u_setup (
        .i_x0    (r_x0),
        .i_y0    (r_y0),
        .i_x1    (r_x1),
        .i_y1    (r_y1),
        .o_line  (setup_line),
        .o_point (setup_point)
    );

    // a step on a busy line waits for the emitter; everything else goes straight through
    assign consume  = r_in_valid && ((r_op == OpStart) || !r_busy || em_take);
    assign start_go = consume && (r_op == OpStart);
    assign step_go  = consume && (r_op == OpStep) && r_busy;
    assign em_load  = step_go;

    assign i_line.ready = !r_in_valid || consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_line.ready) begin
            r_in_valid <= i_line.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_line.ready && i_line.valid) begin
            r_op <= i_line.operation;
            r_x0 <= i_line.start_x;
            r_y0 <= i_line.start_y;
            r_x1 <= i_line.end_x;
            r_y1 <= i_line.end_y;
        end
    end

    always_comb begin
        snap.major = r_line.major_pos;
        snap.minor = r_line.minor_pos;
        snap.steep = (r_line.cls == ClsSteepPos) || (r_line.cls == ClsSteepNeg);
        snap.done  = (r_line.major_pos == r_line.major_end);
        ea = t_dec'(r_line.delta_y);
        eb = t_dec'(r_line.neg_delta_x);
    end

    always_comb begin
        n_busy = r_busy;
        n_line = r_line;
        if (start_go && !setup_point) begin
            n_busy = 1'b1;
            n_line = setup_line;
        end else if (step_go) begin
            if (snap.done) begin
                n_busy = 1'b0;
            end else begin
                unique case (r_line.cls)
                    ClsShallowPos: begin
                        if (r_line.decision <= 0) begin
                            n_line.decision = r_line.decision + (ea <<< 1);
                        end else begin
                            n_line.decision  = r_line.decision + ((ea + eb) <<< 1);
                            n_line.minor_pos = r_line.minor_pos + t_coord'(1);
                        end
                        n_line.major_pos = r_line.major_pos + t_coord'(1);
                    end
                    ClsSteepPos: begin
                        if (r_line.decision < 0) begin
                            n_line.decision  = r_line.decision + ((ea + eb) <<< 1);
                            n_line.minor_pos = r_line.minor_pos + t_coord'(1);
                        end else begin
                            n_line.decision = r_line.decision + (eb <<< 1);
                        end
                        n_line.major_pos = r_line.major_pos + t_coord'(1);
                    end
                    ClsShallowNeg: begin
                        if (r_line.decision < 0) begin
                            n_line.decision  = r_line.decision + ((ea - eb) <<< 1);
                            n_line.minor_pos = r_line.minor_pos - t_coord'(1);
                        end else begin
                            n_line.decision = r_line.decision + (ea <<< 1);
                        end
                        n_line.major_pos = r_line.major_pos + t_coord'(1);
                    end
                    ClsSteepNeg: begin
                        if (r_line.decision >= 0) begin
                            n_line.decision  = r_line.decision + ((ea - eb) <<< 1);
                            n_line.minor_pos = r_line.minor_pos + t_coord'(1);
                        end else begin
                            n_line.decision = r_line.decision - (eb <<< 1);
                        end
                        // major axis walks downward here
                        n_line.major_pos = r_line.major_pos - t_coord'(1);
                    end
                    default: n_line = r_line;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_line <= '0;
        end else begin
            r_busy <= n_busy;
            r_line <= n_line;
        end
    end

    tlr_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (em_load),
        .i_snap  (snap),
        .o_take  (em_take),
        .o_pix   (o_pix)
    );

    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        em_load |-> em_take)
        else $error("emitter loaded while still holding pixels of a step");

    a_point_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start_go && setup_point |=> (r_busy == $past(r_busy)) && (r_line == $past(r_line)))
        else $error("single-point line changed the line state");

    a_step_done_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_go |=> (r_busy == !$past(snap.done)))
        else $error("busy flag wrong after a step");

    a_idle_only_by_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $fell(r_busy) |-> $past(step_go))
        else $error("line went idle without a final step");

endmodule

// File: dv/tlr_line_checker.sv
// pixel checker for the thick line rasterizer: tracks the line state from the
// accepted input beats and compares every accepted pixel beat in order
// depends on tlr_pkg and tlr_if
`timescale 1ns / 100ps

module tlr_line_checker import tlr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    tlr_in_if    i_line,
    tlr_out_if   i_pix,
    output int   o_err_count,
    output int   o_pend_count
);

    typedef struct {
        t_pix px;
        t_pix py;
        logic last;
        logic done;
    } t_pix_beat;

    t_pix_beat pix_expect_q[$];
    int        err_total = 0;

    // tracked line state
    logic   line_busy;
    t_class line_cls;
    t_coord maj_pos;
    t_coord min_pos;
    t_coord maj_end;
    t_diff  dy_r;
    t_diff  ndx_r;
    t_dec   dec_r;

    function automatic int mag(int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic void line_setup(t_coord sx, t_coord sy, t_coord ex, t_coord ey);
        int     x0, y0, x1, y1, ddx, ddy, tmp, a, b;
        t_class cls;
        x0 = sx;
        y0 = sy;
        x1 = ex;
        y1 = ey;
        ddx = x1 - x0;
        ddy = y1 - y0;
        // a single point is dropped without touching the state
        if (ddx == 0 && ddy == 0) return;
        if (ddx == 0) begin
            cls = (ddy > 0) ? ClsSteepPos : ClsSteepNeg;
        end else if (ddy == 0 || ((ddx > 0) == (ddy > 0))) begin
            cls = (mag(ddy) <= mag(ddx)) ? ClsShallowPos : ClsSteepPos;
        end else begin
            cls = (mag(ddy) <= mag(ddx)) ? ClsShallowNeg : ClsSteepNeg;
        end
        // steep positive walks y upward, the rest walk x upward
        if ((cls == ClsSteepPos && y0 > y1) || (cls != ClsSteepPos && x0 > x1)) begin
            tmp = x0; x0 = x1; x1 = tmp;
            tmp = y0; y0 = y1; y1 = tmp;
        end
        a = y1 - y0;
        b = x0 - x1;
        line_cls = cls;
        dy_r     = t_diff'(a);
        ndx_r    = t_diff'(b);
        if (cls == ClsShallowPos || cls == ClsShallowNeg) begin
            maj_pos = t_coord'(x0);
            min_pos = t_coord'(y0);
            maj_end = t_coord'(x1);
        end else begin
            maj_pos = t_coord'(y0);
            min_pos = t_coord'(x0);
            maj_end = t_coord'(y1);
        end
        case (cls)
            ClsShallowPos: dec_r = t_dec'(2 * a + b);
            ClsSteepPos:   dec_r = t_dec'(a + 2 * b);
            ClsShallowNeg: dec_r = t_dec'(2 * a - b);
            default:       dec_r = t_dec'(a - 2 * b);
        endcase
        line_busy = 1'b1;
    endfunction

    function automatic void step_pixels();
        int        offs [5] = '{0, 1, -1, 2, -2};
        logic      fin;
        logic      steep;
        int        a, b, d, px, py;
        t_pix_beat beat;
        fin   = (maj_pos == maj_end);
        steep = (line_cls == ClsSteepPos || line_cls == ClsSteepNeg);
        for (int k = 0; k < 5; k++) begin
            if (steep) begin
                px = int'(min_pos) + offs[k];
                py = int'(maj_pos);
            end else begin
                px = int'(maj_pos);
                py = int'(min_pos) + offs[k];
            end
            beat.px   = t_pix'(px);
            beat.py   = t_pix'(py);
            beat.last = (k == 4);
            beat.done = fin;
            pix_expect_q.push_back(beat);
        end
        if (fin) begin
            line_busy = 1'b0;
            return;
        end
        a = dy_r;
        b = ndx_r;
        d = dec_r;
        case (line_cls)
            ClsShallowPos: begin
                if (d <= 0) begin
                    d += 2 * a;
                end else begin
                    d += 2 * (a + b);
                    min_pos = t_coord'(min_pos + 1);
                end
                maj_pos = t_coord'(maj_pos + 1);
            end
            ClsSteepPos: begin
                if (d < 0) begin
                    d += 2 * (a + b);
                    min_pos = t_coord'(min_pos + 1);
                end else begin
                    d += 2 * b;
                end
                maj_pos = t_coord'(maj_pos + 1);
            end
            ClsShallowNeg: begin
                if (d < 0) begin
                    d += 2 * (a - b);
                    min_pos = t_coord'(min_pos - 1);
                end else begin
                    d += 2 * a;
                end
                maj_pos = t_coord'(maj_pos + 1);
            end
            default: begin
                // steep negative walks y downward
                if (d >= 0) begin
                    d += 2 * (a - b);
                    min_pos = t_coord'(min_pos + 1);
                end else begin
                    d -= 2 * b;
                end
                maj_pos = t_coord'(maj_pos - 1);
            end
        endcase
        dec_r = t_dec'(d);
    endfunction

    function automatic void check_pixel();
        t_pix_beat want;
        if (pix_expect_q.size() == 0) begin
            $error("pixel beat with nothing expected: x %0d y %0d",
                   i_pix.pixel_x, i_pix.pixel_y);
            err_total++;
            return;
        end
        want = pix_expect_q.pop_front();
        if (i_pix.pixel_x !== want.px) begin
            $error("pixel_x mismatch: expected %0d, got %0d", want.px, i_pix.pixel_x);
            err_total++;
        end
        if (i_pix.pixel_y !== want.py) begin
            $error("pixel_y mismatch: expected %0d, got %0d", want.py, i_pix.pixel_y);
            err_total++;
        end
        if (i_pix.last_of_step !== want.last) begin
            $error("last_of_step mismatch: expected %0b, got %0b",
                   want.last, i_pix.last_of_step);
            err_total++;
        end
        if (i_pix.line_done !== want.done) begin
            $error("line_done mismatch: expected %0b, got %0b",
                   want.done, i_pix.line_done);
            err_total++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            line_busy = 1'b0;
            line_cls  = ClsShallowPos;
            maj_pos   = '0;
            min_pos   = '0;
            maj_end   = '0;
            dy_r      = '0;
            ndx_r     = '0;
            dec_r     = '0;
            pix_expect_q.delete();
        end else begin
            if (i_pix.valid && i_pix.ready) check_pixel();
            if (i_line.valid && i_line.ready) begin
                if (i_line.operation == OpStart) begin
                    line_setup(i_line.start_x, i_line.start_y, i_line.end_x, i_line.end_y);
                end else if (line_busy) begin
                    step_pixels();
                end
            end
        end
        o_err_count  <= err_total;
        o_pend_count <= pix_expect_q.size();
    end

endmodule

// File: dv/tb_thick_line_rasterizer.sv
// testbench top for the thick line rasterizer: clock, reset, line and step beats,
// pixel back-pressure and the verdict
// depends on tlr_pkg, tlr_if, thick_line_rasterizer and tlr_line_checker
`timescale 1ns / 100ps

module tb_thick_line_rasterizer;
    import tlr_pkg::*;

    localparam int HoldCycles = 120;

    logic clk = 1'b0;
    logic rst_n;
    int   err_count;
    int   pend_count;
    int   item_cnt = 0;
    logic idle_en = 1'b1;
    logic hold_req = 1'b0;

    tlr_in_if  line_bus ();
    tlr_out_if pix_bus ();

    thick_line_rasterizer dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_line  (line_bus),
        .o_pix   (pix_bus)
    );

    tlr_line_checker chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_line       (line_bus),
        .i_pix        (pix_bus),
        .o_err_count  (err_count),
        .o_pend_count (pend_count)
    );

    always #1 clk = ~clk;

    initial begin
        #400000;
        $display("FAIL");
        $finish;
    end

    // pixel side: random stalls, plus one long hold-off on request
    initial begin
        logic hold_taken;
        hold_taken = 1'b0;
        pix_bus.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req && !hold_taken) begin
                pix_bus.ready <= 1'b0;
                repeat (HoldCycles) @(posedge clk);
                hold_taken = 1'b1;
            end
            pix_bus.ready <= !(idle_en && $urandom_range(99) < 18);
        end
    end

    task automatic send_beat(logic op, int sx, int sy, int ex, int ey);
        if (idle_en) begin
            while ($urandom_range(99) < 18) begin
                line_bus.valid <= 1'b0;
                @(posedge clk);
            end
        end
        line_bus.valid     <= 1'b1;
        line_bus.operation <= op;
        line_bus.start_x   <= t_coord'(sx);
        line_bus.start_y   <= t_coord'(sy);
        line_bus.end_x     <= t_coord'(ex);
        line_bus.end_y     <= t_coord'(ey);
        do @(posedge clk); while (!line_bus.ready);
    endtask

    task automatic send_step();
        send_beat(OpStep, int'($urandom_range(4095)) - 2048, int'($urandom_range(4095)) - 2048,
                  int'($urandom_range(4095)) - 2048, int'($urandom_range(4095)) - 2048);
    endtask

    // start beat followed by a number of step beats
    task automatic draw_line(int sx, int sy, int ex, int ey, int steps);
        send_beat(OpStart, sx, sy, ex, ey);
        repeat (steps) send_step();
        item_cnt += 1 + steps;
    endtask

    task automatic wait_drained();
        line_bus.valid <= 1'b0;
        do @(posedge clk); while (pend_count != 0);
    endtask

    task automatic random_line();
        int span, ddx, ddy, x0, y0, steps, cut;
        span = ($urandom_range(24) == 0) ? int'($urandom_range(30, 120))
                                         : int'($urandom_range(1, 10));
        ddx = int'($urandom_range(2 * span)) - span;
        ddy = int'($urandom_range(2 * span)) - span;
        if (ddx == 0 && ddy == 0) ddx = span;
        x0 = int'($urandom_range(4095)) - 2048;
        y0 = int'($urandom_range(4095)) - 2048;
        if (x0 + ddx > 2047 || x0 + ddx < -2048) ddx = -ddx;
        if (y0 + ddy > 2047 || y0 + ddy < -2048) ddy = -ddy;
        steps = ((ddx < 0 ? -ddx : ddx) > (ddy < 0 ? -ddy : ddy))
              ? (ddx < 0 ? -ddx : ddx) : (ddy < 0 ? -ddy : ddy);
        steps += 1;
        cut = int'($urandom_range(99));
        // mostly complete lines; some abandoned early, some with extra idle steps
        if (cut < 8) steps = int'($urandom_range(steps - 1));
        else if (cut < 16) steps += int'($urandom_range(1, 3));
        draw_line(x0, y0, x0 + ddx, y0 + ddy, steps);
    endtask

    initial begin
        int pick;
        logic held;
        logic drained;
        held    = 1'b0;
        drained = 1'b0;
        rst_n              <= 1'b0;
        line_bus.valid     <= 1'b0;
        line_bus.operation <= OpStep;
        line_bus.start_x   <= '0;
        line_bus.start_y   <= '0;
        line_bus.end_x     <= '0;
        line_bus.end_y     <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // step while idle, then a single point, both ignored
        send_step();
        send_beat(OpStart, -5, 7, -5, 7);
        send_step();
        // shallow rising, then one step past the end
        draw_line(3, 3, 5, 4, 4);
        // vertical upward and downward
        draw_line(10, -2, 10, 0, 3);
        draw_line(0, 1, 0, 0, 2);
        // shallow falling given right to left
        draw_line(1, 0, -1, 1, 3);
        // long lines between corners or near them, each abandoned by the next start
        draw_line(-2048, -2048, 2047, 2047, 2);
        draw_line(2047, -2048, -2048, 2047, 1);
        draw_line(2047, 2047, 2047, -2048, 1);
        draw_line(-2048, 2047, -2047, -2048, 2);

        while (item_cnt < 430) begin
            idle_en = !(item_cnt >= 60 && item_cnt < 170);
            if (item_cnt >= 220 && !held) begin
                hold_req = 1'b1;
                held = 1'b1;
            end
            if (item_cnt >= 320 && !drained) begin
                wait_drained();
                drained = 1'b1;
            end
            pick = int'($urandom_range(99));
            if (pick < 80) begin
                random_line();
            end else if (pick < 90) begin
                // full range endpoints, only a few steps
                draw_line(int'($urandom_range(4095)) - 2048, int'($urandom_range(4095)) - 2048,
                          int'($urandom_range(4095)) - 2048, int'($urandom_range(4095)) - 2048,
                          int'($urandom_range(3)));
            end else if (pick < 94) begin
                pick = int'($urandom_range(4095)) - 2048;
                send_beat(OpStart, pick, -pick - 1, pick, -pick - 1);
                item_cnt++;
            end else begin
                send_step();
                item_cnt++;
            end
        end
        idle_en = 1'b1;

        wait_drained();
        repeat (20) @(posedge clk);
        if (err_count == 0 && pend_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
